// ===== hw/rtl/lir_pkg.sv =====
// shared constants and types for the linear interpolation resampler
package lir_pkg;

    // sample and phase formats
    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSAMPLE = 16;

    localparam int PHASE_BITS = FRAC_BITS + 5;
    localparam int PROD_W     = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int QUOT_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W      = QUOT_W + 1;

    // phase constants
    localparam logic [PHASE_BITS-1:0] ONE_Q    = PHASE_BITS'(64'd1 << FRAC_BITS);
    localparam logic [PHASE_BITS-1:0] TWO_Q    = PHASE_BITS'(64'd2 << FRAC_BITS);
    localparam logic [PHASE_BITS-1:0] MIN_STEP =
        PHASE_BITS'(((64'd1 << FRAC_BITS) + 64'(MAX_UPSAMPLE) - 64'd1) / 64'(MAX_UPSAMPLE));
    localparam logic [PHASE_BITS-1:0] MAX_STEP = PHASE_BITS'(64'd16 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(64'd1 << (FRAC_BITS - 1));

    // sample range for saturation
    localparam logic signed [SUM_W-1:0] SMP_MAX =
        SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SMP_MIN = -SMP_MAX - SUM_W'(1);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG,
        S_MUL,
        S_EMIT,
        S_TAIL
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic mul;
        logic emit_interp;
        logic emit_tail;
        logic wrap;
        logic finish;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic have_prev;
        logic fin;
        logic ph_lt_one;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/linear_interp_resampler.sv =====
// top level of the linear interpolation resampler
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------------
//   input    | in        | i_in_valid / o_in_stall    | i_sample_in, i_is_final
//   output   | out       | o_out_valid / i_out_stall  | o_sample_out, o_run_last, o_stream_end
//   config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_step_ratio
//
// an input beat is loaded, then each interpolated output passes the phase check,
// the multiply into the product register and the rounding into the output register
// in turn, and repeated tail outputs follow. the input is stalled while the
// controller is out of idle, after acceptance until the finish step that follows the
// item's last result; the output register then waits on its own, and an output stall
// holds the emitting state. reset is synchronous, active low, and restores step 1.0
// with an empty history.
module linear_interp_resampler
    import lir_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [PHASE_BITS-1:0]         i_cfg_step_ratio,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_is_final,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_run_last,
    output logic                          o_stream_end
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // config register is always writable
    assign o_cfg_ready = 1'b1;

    // sequencer
    lir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    lir_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_step_ratio (i_cfg_step_ratio),
        .i_sample_in      (i_sample_in),
        .i_is_final       (i_is_final),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_sample_out     (o_sample_out),
        .o_run_last       (o_run_last),
        .o_stream_end     (o_stream_end)
    );

endmodule

// ===== hw/rtl/lir_dp.sv =====
// datapath: sample and phase registers, interpolation multiplier, output register
module lir_dp
    import lir_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_stat                      o_stat,
    input  logic                          i_cfg_valid,
    input  logic [PHASE_BITS-1:0]         i_cfg_step_ratio,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_is_final,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_run_last,
    output logic                          o_stream_end
);

    // control state
    logic [PHASE_BITS-1:0]         r_step;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic                          r_have_prev;
    logic [PHASE_BITS-1:0]         r_phase;
    logic                          r_out_valid;

    // per-item payload
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic                          r_fin;
    logic signed [SAMPLE_BITS:0]   r_diff;
    logic [PHASE_BITS-1:0]         r_stepc;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_last;
    logic                          r_out_end;

    logic signed [SAMPLE_BITS:0]   n_diff;
    logic [PHASE_BITS-1:0]         n_stepc;
    logic signed [FRAC_BITS:0]     w_frac;
    logic signed [PROD_W-1:0]      w_prod;
    logic signed [PROD_W-1:0]      w_round;
    logic signed [QUOT_W-1:0]      w_quot;
    logic signed [SUM_W-1:0]       w_sum;
    logic signed [SAMPLE_BITS-1:0] w_interp;
    logic [PHASE_BITS-1:0]         w_ph_step;
    logic                          w_interp_last;
    logic                          w_tail_last;
    logic                          w_out_free;

    // difference and clamped step for a new item
    assign n_diff = {i_sample_in[SAMPLE_BITS-1], i_sample_in}
                  - {r_prev[SAMPLE_BITS-1], r_prev};

    always_comb begin
        n_stepc = r_step;
        if (r_step < MIN_STEP) begin
            n_stepc = MIN_STEP;
        end else if (r_step > MAX_STEP) begin
            n_stepc = MAX_STEP;
        end
    end

    // multiplier: difference times phase fraction
    assign w_frac = {1'b0, r_phase[FRAC_BITS-1:0]};
    assign w_prod = r_diff * w_frac;

    // round, arithmetic shift, add previous sample, saturate
    assign w_round = r_prod + HALF_P;
    assign w_quot  = w_round[PROD_W-1:FRAC_BITS];
    assign w_sum   = {{(SUM_W-SAMPLE_BITS){r_prev[SAMPLE_BITS-1]}}, r_prev}
                   + {w_quot[QUOT_W-1], w_quot};

    always_comb begin
        if (w_sum > SMP_MAX) begin
            w_interp = SMP_MAX[SAMPLE_BITS-1:0];
        end else if (w_sum < SMP_MIN) begin
            w_interp = SMP_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_interp = w_sum[SAMPLE_BITS-1:0];
        end
    end

    // phase advance and last-beat lookahead
    assign w_ph_step     = r_phase + r_stepc;
    assign w_interp_last = (w_ph_step >= ONE_Q) && !(r_fin && (w_ph_step < TWO_Q));
    assign w_tail_last   = (w_ph_step >= ONE_Q);
    assign w_out_free    = !r_out_valid || !i_out_stall;

    // status
    assign o_stat.have_prev = r_have_prev;
    assign o_stat.fin       = r_fin;
    assign o_stat.ph_lt_one = (r_phase < ONE_Q);
    assign o_stat.out_free  = w_out_free;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ONE_Q;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_step_ratio;
            end
            if (i_cmd.load_in && !r_have_prev) begin
                r_phase <= '0;
            end
            if (i_cmd.wrap) begin
                r_phase <= r_phase - ONE_Q;
            end
            if (i_cmd.emit_interp || i_cmd.emit_tail) begin
                r_phase     <= w_ph_step;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                if (r_fin) begin
                    r_prev      <= '0;
                    r_have_prev <= 1'b0;
                    r_phase     <= '0;
                end else begin
                    r_prev      <= r_x;
                    r_have_prev <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x     <= i_sample_in;
            r_fin   <= i_is_final;
            r_diff  <= n_diff;
            r_stepc <= n_stepc;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.emit_interp) begin
            r_out_sample <= w_interp;
            r_out_last   <= w_interp_last;
            r_out_end    <= w_interp_last && r_fin;
        end else if (i_cmd.emit_tail) begin
            r_out_sample <= r_x;
            r_out_last   <= w_tail_last;
            r_out_end    <= w_tail_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_run_last   = r_out_last;
    assign o_stream_end = r_out_end;

endmodule

// ===== hw/rtl/lir_ctrl.sv =====
// controller: sequences segment beats, tail repeats and state update per input
module lir_ctrl
    import lir_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_SEG;
                end
            end
            S_SEG: begin
                if (i_stat.have_prev && i_stat.ph_lt_one) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.wrap = i_stat.have_prev;
                    n_state    = S_TAIL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_interp = 1'b1;
                    n_state           = S_SEG;
                end
            end
            S_TAIL: begin
                if (i_stat.fin && i_stat.ph_lt_one) begin
                    o_cmd.emit_tail = i_stat.out_free;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
